// ----- src/tkvt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkvt_pkg
// Shared types and defaults for the thread-keyed value table.
// ----------------------------------------------------------------------------
package tkvt_pkg;

    localparam int KEYS_DEF  = 32;
    localparam int SLOTS_DEF = 256;

    localparam int TID_W = 32;
    localparam int KEY_W = 6;
    localparam int VAL_W = 32;

    typedef enum logic [1:0] {
        FN_CREATE = 2'd0,
        FN_SET    = 2'd1,
        FN_GET    = 2'd2,
        FN_DELETE = 2'd3
    } func_t;

    // one slot of the table as held in the slot RAM
    typedef struct packed {
        logic             in_use;
        logic [KEY_W-1:0] key;
        logic [TID_W-1:0] thread_id;
        logic [VAL_W-1:0] value;
    } slot_entry_t;

    // result of comparing one slot against the current request
    typedef struct packed {
        logic hit;      // in use, same thread and key
        logic key_hit;  // in use, same key (any thread)
        logic free;     // not in use
    } slot_match_t;

endpackage

// ----- src/tkvt_slot_match.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkvt_slot_match
// Compare unit shared by every slot scan: checks one slot against thread and key.
// ----------------------------------------------------------------------------
module tkvt_slot_match (
    input  tkvt_pkg::slot_entry_t          entry,
    input  logic [tkvt_pkg::TID_W-1:0]     thread_id,
    input  logic [tkvt_pkg::KEY_W-1:0]     key,
    output tkvt_pkg::slot_match_t          result
);
    import tkvt_pkg::*;

    logic key_eq;
    logic tid_eq;

    assign key_eq = (entry.key == key);
    assign tid_eq = (entry.thread_id == thread_id);

    assign result.hit     = entry.in_use & key_eq & tid_eq;
    assign result.key_hit = entry.in_use & key_eq;
    assign result.free    = ~entry.in_use;

endmodule

// ----- src/thread_keyed_value_table_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thread_keyed_value_table_core
// Key allocator plus a flat slot table keyed by thread and key number.
//
//   channel | dir | ports                                   | transfer when
//   --------+-----+-----------------------------------------+------------------
//   request | in  | s_func s_thread_id s_key s_value        | s_valid & s_ready
//   result  | out | m_status m_new_key m_value_out          | m_valid & m_ready
//
// Create scans key_used one key a cycle.
// Set, get and delete stream the slot RAM through one read port and the
// shared compare unit; get and set stop at a hit.
// After reset a clearing pass empties the slot RAM; s_ready stays low
// meanwhile. One request at a time: s_ready is low from the request transfer
// until the result transfer; the result is held while m_ready is low.
// ----------------------------------------------------------------------------
module thread_keyed_value_table_core #(
    parameter int KEYS  = tkvt_pkg::KEYS_DEF,
    parameter int SLOTS = tkvt_pkg::SLOTS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  s_func,
    input  logic [tkvt_pkg::TID_W-1:0]  s_thread_id,
    input  logic [tkvt_pkg::KEY_W-1:0]  s_key,
    input  logic [tkvt_pkg::VAL_W-1:0]  s_value,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_status,
    output logic [tkvt_pkg::KEY_W-1:0]  m_new_key,
    output logic [tkvt_pkg::VAL_W-1:0]  m_value_out
);
    import tkvt_pkg::*;

    localparam int SLOT_AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int KEY_AW  = (KEYS > 1) ? $clog2(KEYS) : 1;
    localparam logic [SLOT_AW-1:0] SLOT_LAST = SLOT_AW'(SLOTS - 1);
    localparam logic [KEY_AW-1:0]  KEY_LAST  = KEY_AW'(KEYS - 1);

    typedef enum logic [4:0] {
        ST_CLEAR   = 5'b00001,
        ST_IDLE    = 5'b00010,
        ST_KEYSCAN = 5'b00100,
        ST_SCAN    = 5'b01000,
        ST_RESP    = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [KEYS-1:0]    key_used_reg, key_used_next;
    logic [SLOT_AW-1:0] idx_reg, idx_next;
    logic [KEY_AW-1:0]  kidx_reg, kidx_next;
    logic               issue_done_reg, issue_done_next;
    logic               rd_vld_reg, rd_vld_next;
    logic [SLOT_AW-1:0] rd_tag_reg, rd_tag_next;
    logic               free_found_reg, free_found_next;
    logic [SLOT_AW-1:0] free_idx_reg, free_idx_next;

    func_t              op_func_reg, op_func_next;
    logic [TID_W-1:0]   op_tid_reg, op_tid_next;
    logic [KEY_W-1:0]   op_key_reg, op_key_next;
    logic [VAL_W-1:0]   op_val_reg, op_val_next;

    logic               status_reg, status_next;
    logic [KEY_W-1:0]   new_key_reg, new_key_next;
    logic [VAL_W-1:0]   vout_reg, vout_next;

    // slot RAM
    slot_entry_t        slot_mem [SLOTS];
    slot_entry_t        rd_data_reg;
    logic               wr_en;
    logic [SLOT_AW-1:0] wr_addr;
    slot_entry_t        wr_data;

    slot_match_t        match;
    logic               key_ok;
    logic               rd_last;

    tkvt_slot_match u_match (
        .entry     (rd_data_reg),
        .thread_id (op_tid_reg),
        .key       (op_key_reg),
        .result    (match)
    );

    assign key_ok  = s_key inside {[KEY_W'(1) : KEY_W'(KEYS)]};
    assign rd_last = (rd_tag_reg == SLOT_LAST);

    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = (state_reg == ST_RESP);
    assign m_status    = status_reg;
    assign m_new_key   = new_key_reg;
    assign m_value_out = vout_reg;

    always_comb begin
        state_next      = state_reg;
        key_used_next   = key_used_reg;
        idx_next        = idx_reg;
        kidx_next       = kidx_reg;
        issue_done_next = issue_done_reg;
        rd_vld_next     = 1'b0;
        rd_tag_next     = rd_tag_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        op_func_next    = op_func_reg;
        op_tid_next     = op_tid_reg;
        op_key_next     = op_key_reg;
        op_val_next     = op_val_reg;
        status_next     = status_reg;
        new_key_next    = new_key_reg;
        vout_next       = vout_reg;
        wr_en           = 1'b0;
        wr_addr         = rd_tag_reg;
        wr_data         = '{in_use: 1'b1, key: op_key_reg, thread_id: op_tid_reg,
                            value: op_val_reg};

        case (state_reg)
            ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = idx_reg;
                wr_data = '0;
                if (idx_reg == SLOT_LAST) begin
                    state_next = ST_IDLE;
                end else begin
                    idx_next = idx_reg + SLOT_AW'(1);
                end
            end

            ST_IDLE: begin
                if (s_valid) begin
                    op_func_next    = func_t'(s_func);
                    op_tid_next     = s_thread_id;
                    op_key_next     = s_key;
                    op_val_next     = s_value;
                    status_next     = 1'b1;
                    new_key_next    = '0;
                    vout_next       = '0;
                    idx_next        = '0;
                    kidx_next       = '0;
                    issue_done_next = 1'b0;
                    free_found_next = 1'b0;
                    if (func_t'(s_func) == FN_CREATE) begin
                        state_next = ST_KEYSCAN;
                    end else if (!key_ok) begin
                        state_next = ST_RESP;
                    end else begin
                        state_next = ST_SCAN;
                        if (func_t'(s_func) == FN_DELETE) begin
                            key_used_next[KEY_AW'(s_key - KEY_W'(1))] = 1'b0;
                        end
                    end
                end
            end

            ST_KEYSCAN: begin
                if (!key_used_reg[kidx_reg]) begin
                    key_used_next[kidx_reg] = 1'b1;
                    status_next  = 1'b0;
                    new_key_next = KEY_W'(kidx_reg) + KEY_W'(1);
                    state_next   = ST_RESP;
                end else if (kidx_reg == KEY_LAST) begin
                    state_next = ST_RESP;
                end else begin
                    kidx_next = kidx_reg + KEY_AW'(1);
                end
            end

            ST_SCAN: begin
                // read issue: one address a cycle, data back the next cycle
                if (!issue_done_reg) begin
                    rd_vld_next = 1'b1;
                    rd_tag_next = idx_reg;
                    if (idx_reg == SLOT_LAST) begin
                        issue_done_next = 1'b1;
                    end else begin
                        idx_next = idx_reg + SLOT_AW'(1);
                    end
                end
                // compare stage on the registered read data
                if (rd_vld_reg) begin
                    case (op_func_reg)
                        FN_SET: begin
                            if (match.hit) begin
                                wr_en       = 1'b1;
                                status_next = 1'b0;
                                state_next  = ST_RESP;
                            end else begin
                                if (match.free && !free_found_reg) begin
                                    free_found_next = 1'b1;
                                    free_idx_next   = rd_tag_reg;
                                end
                                if (rd_last) begin
                                    state_next = ST_RESP;
                                    if (free_found_reg || match.free) begin
                                        wr_en       = 1'b1;
                                        wr_addr     = free_found_reg ? free_idx_reg
                                                                     : rd_tag_reg;
                                        status_next = 1'b0;
                                    end
                                end
                            end
                        end
                        FN_GET: begin
                            if (match.hit) begin
                                vout_next   = rd_data_reg.value;
                                status_next = 1'b0;
                                state_next  = ST_RESP;
                            end else if (rd_last) begin
                                state_next = ST_RESP;
                            end
                        end
                        FN_DELETE: begin
                            if (match.key_hit) begin
                                wr_en          = 1'b1;
                                wr_data        = rd_data_reg;
                                wr_data.in_use = 1'b0;
                            end
                            if (rd_last) begin
                                status_next = 1'b0;
                                state_next  = ST_RESP;
                            end
                        end
                        default: begin
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end

            ST_RESP: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            key_used_reg   <= '0;
            idx_reg        <= '0;
            kidx_reg       <= '0;
            issue_done_reg <= 1'b0;
            rd_vld_reg     <= 1'b0;
            free_found_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            key_used_reg   <= key_used_next;
            idx_reg        <= idx_next;
            kidx_reg       <= kidx_next;
            issue_done_reg <= issue_done_next;
            rd_vld_reg     <= rd_vld_next;
            free_found_reg <= free_found_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_tag_reg   <= rd_tag_next;
        free_idx_reg <= free_idx_next;
        op_func_reg  <= op_func_next;
        op_tid_reg   <= op_tid_next;
        op_key_reg   <= op_key_next;
        op_val_reg   <= op_val_next;
        status_reg   <= status_next;
        new_key_reg  <= new_key_next;
        vout_reg     <= vout_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            slot_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= slot_mem[idx_reg];
    end

endmodule

// ----- src/tkvt_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkvt_checker
// Port-level checks on the thread-keyed value table, bound to the top level.
// ----------------------------------------------------------------------------
module tkvt_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic                        m_status,
    input logic [tkvt_pkg::KEY_W-1:0]  m_new_key,
    input logic [tkvt_pkg::VAL_W-1:0]  m_value_out
);
    import tkvt_pkg::*;

    // a pending result holds until its transfer
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_new_key)
                                && $stable(m_value_out))
        else $error("result changed while stalled");

    // one request in flight: no new request while a result waits
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("request taken while result pending");

    a_busy_after_req: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready high straight after request transfer");

    // an allocated key or a returned value only comes with success
    a_key_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_new_key != '0) |-> !m_status)
        else $error("new key reported with error status");

    a_value_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_value_out != '0) |-> !m_status && (m_new_key == '0))
        else $error("value reported with error status or key");

endmodule

bind thread_keyed_value_table_core tkvt_checker u_tkvt_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_status    (m_status),
    .m_new_key   (m_new_key),
    .m_value_out (m_value_out)
);

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for thread_keyed_value_table_core. A table of directed
// requests covers the field extremes and the error cases. Three random phases
// follow: a mixed phase, a fill phase that runs the key allocator and the slot
// table to exhaustion, and a delete-heavy drain phase. Typed rows are checked
// against the table, all else against an in-bench allocator and slot model.
// ----------------------------------------------------------------------------
module testbench;

    import tkvt_pkg::*;

    localparam int NKEYS        = KEYS_DEF;
    localparam int NSLOTS       = SLOTS_DEF;
    localparam int LIMIT        = 1_000_000;
    localparam int DRAIN_CYCLES = NSLOTS + 16;

    typedef struct packed {
        logic             status;
        logic [KEY_W-1:0] new_key;
        logic [VAL_W-1:0] value_out;
    } result_t;

    typedef struct packed {
        func_t            fn;
        logic [TID_W-1:0] tid;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] val;
        logic             typed;
        result_t          want;
    } dir_row_t;

    logic             aclk;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    logic [1:0]       s_func;
    logic [TID_W-1:0] s_thread_id;
    logic [KEY_W-1:0] s_key;
    logic [VAL_W-1:0] s_value;
    logic             m_valid;
    logic             m_ready;
    logic             m_status;
    logic [KEY_W-1:0] m_new_key;
    logic [VAL_W-1:0] m_value_out;

    // model of the allocator and slot table
    bit               key_taken [NKEYS];
    bit               slot_busy [NSLOTS];
    logic [TID_W-1:0] slot_tid  [NSLOTS];
    logic [KEY_W-1:0] slot_keyno[NSLOTS];
    logic [VAL_W-1:0] slot_val  [NSLOTS];

    result_t          answers_due[$];
    dir_row_t         directed_rows[$];
    logic [TID_W-1:0] thread_pool[6];
    result_t          got_result;
    result_t          due;
    int               mismatches;
    int               full_rejects;
    int               cycles;
    bit               steady;

    thread_keyed_value_table_core #(
        .KEYS  (NKEYS),
        .SLOTS (NSLOTS)
    ) u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_func      (s_func),
        .s_thread_id (s_thread_id),
        .s_key       (s_key),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_new_key   (m_new_key),
        .m_value_out (m_value_out)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic int find_slot(logic [TID_W-1:0] tid, logic [KEY_W-1:0] key);
        int i;
        for (i = 0; i < NSLOTS; i++) begin
            if (slot_busy[i] && slot_tid[i] == tid && slot_keyno[i] == key)
                return i;
        end
        return -1;
    endfunction

    function automatic result_t table_apply(func_t fn, logic [TID_W-1:0] tid,
                                            logic [KEY_W-1:0] key, logic [VAL_W-1:0] val);
        result_t r;
        int      hit;
        int      i;
        bit      key_ok;
        r        = '0;
        r.status = 1'b1;
        key_ok   = (key != 0) && (key <= NKEYS);
        case (fn)
            FN_CREATE: begin
                for (i = 0; i < NKEYS; i++) begin
                    if (!key_taken[i]) begin
                        key_taken[i] = 1'b1;
                        r.new_key    = KEY_W'(i + 1);
                        r.status     = 1'b0;
                        break;
                    end
                end
            end
            FN_SET: if (key_ok) begin
                hit = find_slot(tid, key);
                if (hit < 0) begin
                    for (i = 0; i < NSLOTS; i++) begin
                        if (!slot_busy[i]) begin
                            slot_busy[i]  = 1'b1;
                            slot_tid[i]   = tid;
                            slot_keyno[i] = key;
                            hit           = i;
                            break;
                        end
                    end
                end
                if (hit >= 0) begin
                    slot_val[hit] = val;
                    r.status      = 1'b0;
                end else begin
                    full_rejects++;
                end
            end
            FN_GET: if (key_ok) begin
                hit = find_slot(tid, key);
                if (hit >= 0) begin
                    r.value_out = slot_val[hit];
                    r.status    = 1'b0;
                end
            end
            default: if (key_ok) begin
                key_taken[key - 1] = 1'b0;
                // every thread's slot under this key goes
                for (i = 0; i < NSLOTS; i++) begin
                    if (slot_busy[i] && slot_keyno[i] == key)
                        slot_busy[i] = 1'b0;
                end
                r.status = 1'b0;
            end
        endcase
        return r;
    endfunction

    function automatic func_t pick_func(int w_create, int w_set, int w_get);
        int r;
        r = $urandom_range(0, 99);
        if (r < w_create)
            return FN_CREATE;
        if (r < w_create + w_set)
            return FN_SET;
        if (r < w_create + w_set + w_get)
            return FN_GET;
        return FN_DELETE;
    endfunction

    function automatic logic [TID_W-1:0] pick_thread(bit fresh);
        if ($urandom_range(0, 4) == 0 || (fresh && $urandom_range(0, 4) != 0))
            return $urandom();
        return thread_pool[$urandom_range(0, 5)];
    endfunction

    // narrow keys make get and update hits likely; wide spreads the table
    function automatic logic [KEY_W-1:0] pick_key(bit wide);
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return '0;
        if (r < 15)
            return KEY_W'($urandom_range(NKEYS + 1, (1 << KEY_W) - 1));
        if (r < 55 && !wide)
            return KEY_W'($urandom_range(1, 6));
        return KEY_W'($urandom_range(1, NKEYS));
    endfunction

    task automatic add_row(func_t fn, logic [TID_W-1:0] tid, logic [KEY_W-1:0] key,
                           logic [VAL_W-1:0] val, logic typed, logic st,
                           logic [KEY_W-1:0] nk, logic [VAL_W-1:0] vo);
        dir_row_t row;
        row.fn   = fn;
        row.tid  = tid;
        row.key  = key;
        row.val  = val;
        row.typed = typed;
        row.want = '{status: st, new_key: nk, value_out: vo};
        directed_rows.push_back(row);
    endtask

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_req(func_t fn, logic [TID_W-1:0] tid, logic [KEY_W-1:0] key,
                            logic [VAL_W-1:0] val, logic typed, result_t want);
        int      gap;
        result_t predicted;
        if ($urandom_range(0, 29) == 0)
            steady = ~steady;
        gap = steady ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_func      <= fn;
        s_thread_id <= tid;
        s_key       <= key;
        s_value     <= val;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = table_apply(fn, tid, key, val);
        answers_due.push_back(typed ? want : predicted);
        @(negedge aclk);
    endtask

    // result side
    initial begin
        int stall;
        m_ready = 1'b0;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
                m_ready <= 1'b0;
                // sometimes hold off only once the result is on the bus
                if ($urandom_range(0, 1)) begin
                    @(posedge aclk);
                    while (!m_valid) @(posedge aclk);
                    @(negedge aclk);
                end
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            @(negedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            got_result = '{status: m_status, new_key: m_new_key, value_out: m_value_out};
            if (answers_due.size() == 0) begin
                $display("%0t: result transfer with nothing outstanding %s",
                         $time, "(status, key, value follow)");
                $display("%0t: status %0d key %0d value %h",
                         $time, m_status, m_new_key, m_value_out);
                mismatches++;
            end else begin
                due = answers_due.pop_front();
                if (got_result.status !== due.status) begin
                    $display("%0t: m_status expected %0d, got %0d",
                             $time, due.status, got_result.status);
                    mismatches++;
                end
                if (got_result.new_key !== due.new_key) begin
                    $display("%0t: m_new_key expected %0d, got %0d",
                             $time, due.new_key, got_result.new_key);
                    mismatches++;
                end
                if (got_result.value_out !== due.value_out) begin
                    $display("%0t: m_value_out expected %h, got %h",
                             $time, due.value_out, got_result.value_out);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        cycles = 0;
        while (cycles < LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("%0t: timeout after %0d cycles", $time, cycles);
        $display("status: fail");
        $finish;
    end

    initial begin
        int n;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_func      = FN_CREATE;
        s_thread_id = '0;
        s_key       = '0;
        s_value     = '0;
        steady      = 1'b0;
        mismatches  = 0;
        full_rejects = 0;
        thread_pool[0] = '0;
        thread_pool[1] = '1;
        for (n = 2; n < 6; n++)
            thread_pool[n] = $urandom();

        //      func       thread        key  value         typed st key value
        add_row(FN_GET,    32'h0,        1,   32'h0,        1, 1, 0, 32'h0);
        add_row(FN_CREATE, 32'h0,        0,   32'h0,        1, 0, 1, 32'h0);
        add_row(FN_CREATE, 32'hFFFFFFFF, 63,  32'hFFFFFFFF, 1, 0, 2, 32'h0);
        add_row(FN_SET,    32'h0,        1,   32'h0,        1, 0, 0, 32'h0);
        add_row(FN_GET,    32'h0,        1,   32'hFFFFFFFF, 1, 0, 0, 32'h0);
        add_row(FN_SET,    32'hFFFFFFFF, 32,  32'hFFFFFFFF, 1, 0, 0, 32'h0);
        add_row(FN_GET,    32'hFFFFFFFF, 32,  32'h0,        1, 0, 0, 32'hFFFFFFFF);
        add_row(FN_SET,    32'h0,        0,   32'h1,        1, 1, 0, 32'h0);
        add_row(FN_GET,    32'h0,        33,  32'h0,        1, 1, 0, 32'h0);
        add_row(FN_DELETE, 32'h0,        63,  32'h0,        1, 1, 0, 32'h0);
        add_row(FN_DELETE, 32'h0,        0,   32'h0,        1, 1, 0, 32'h0);
        add_row(FN_SET,    32'h0,        63,  32'h2,        1, 1, 0, 32'h0);
        add_row(FN_SET,    32'hFFFFFFFF, 1,   32'h12345678, 0, 0, 0, 32'h0);
        add_row(FN_SET,    32'h0,        1,   32'hA5A5A5A5, 0, 0, 0, 32'h0);
        add_row(FN_GET,    32'h0,        1,   32'h0,        0, 0, 0, 32'h0);
        add_row(FN_GET,    32'hFFFFFFFF, 1,   32'h0,        0, 0, 0, 32'h0);
        add_row(FN_DELETE, 32'h0,        1,   32'h0,        1, 0, 0, 32'h0);
        add_row(FN_GET,    32'h0,        1,   32'h0,        1, 1, 0, 32'h0);
        add_row(FN_GET,    32'hFFFFFFFF, 32,  32'h0,        0, 0, 0, 32'h0);
        add_row(FN_DELETE, 32'h0,        20,  32'h0,        1, 0, 0, 32'h0);
        add_row(FN_CREATE, 32'h0,        0,   32'h0,        0, 0, 0, 32'h0);
        add_row(FN_SET,    32'h5A5A5A5A, 20,  32'h5A5A5A5A, 0, 0, 0, 32'h0);
        add_row(FN_GET,    32'h5A5A5A5A, 20,  32'h0,        0, 0, 0, 32'h0);
        add_row(FN_DELETE, 32'h0,        32,  32'h0,        1, 0, 0, 32'h0);
        add_row(FN_GET,    32'hFFFFFFFF, 32,  32'h0,        1, 1, 0, 32'h0);

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_rows[r])
            send_req(directed_rows[r].fn, directed_rows[r].tid, directed_rows[r].key,
                     directed_rows[r].val, directed_rows[r].typed, directed_rows[r].want);

        // mixed traffic over a handful of threads
        repeat (150)
            send_req(pick_func(15, 40, 30), pick_thread(1'b0), pick_key(1'b0),
                     $urandom(), 1'b0, '0);

        // no deletes: run out of keys and slots, then keep knocking
        n = 0;
        while (full_rejects < 12 && n < 450) begin
            send_req(pick_func(15, 75, 10), pick_thread(1'b1), pick_key(1'b1),
                     $urandom(), 1'b0, '0);
            n++;
        end

        // delete-heavy drain
        repeat (100)
            send_req(pick_func(15, 25, 25), pick_thread(1'b0), pick_key(1'b0),
                     $urandom(), 1'b0, '0);

        s_valid <= 1'b0;
        while (answers_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
